// File: src/erm_pkg.sv
// Shared types and constants for the Euler-angle rotation matrix pipeline.
package erm_pkg;

  // Unsigned Q30 fraction, 0 .. 1.0 inclusive
  typedef logic [30:0] q30_t;
  // Signed Q30 sine or cosine
  typedef logic signed [31:0] trig_t;
  // One Q2.14 matrix element and the upper-left 3x3 block, [row][col]
  typedef logic signed [15:0] elem_t;
  typedef logic [2:0][2:0][15:0] mat3_t;

  localparam q30_t        Q30_ONE      = 31'h4000_0000;
  localparam logic [61:0] Q30_HALF     = 62'h2000_0000;
  localparam logic [30:0] PI_2_Q30     = 31'd1686629713;
  localparam int          HORNER_TERMS = 8;
  // x, x^2, three stages per Horner term, final product
  localparam int          KERNEL_LAT   = 2 + 3 * HORNER_TERMS + 1;
  localparam int          DEG_QUARTER  = 90;
  localparam logic [1:0]  LAST_ROW     = 2'd3;

  // Taylor denominator (2k)(2k+1) for Horner term k
  function automatic int horner_div(input int k);
    return (2 * k) * (2 * k + 1);
  endfunction

endpackage

// File: src/euler_rotation_matrix.sv
// Top level: Euler-angle (Z*Y*X) rotation matrix, one angle triple in, four rows out.
//
//  port group   dir  tdata bits (low to high)                                  tlast
//  s_axis       in   angle_x[15:0] angle_y[31:16] angle_z[47:32]                -
//  m_axis       out  row_index[1:0] elem_col0..3 [17:2],[33:18],[49:34],[65:50] last_row
//
//  The path from an accepted triple to row 0 runs through the sine/cosine
//  pipes, the matrix products and the output register.
//  Each triple occupies the output for four row words, one per row, so the single
//  result channel, held further by back-pressure on m_axis, sets the sustained rate.
//  All pipeline stages advance together; they hold while a finished matrix waits
//  for the output stage, and a new triple is taken whenever they advance.
//  Reset clears the valid bits and the output row counter only.
module euler_rotation_matrix #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int ELEM_FRAC_BITS  = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // angle_x, angle_y, angle_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // row_index, elem_col0..elem_col3, zero pad
  output logic        m_axis_tlast_o    // last_row
);

  logic           en;
  logic           vx, vy, vz, mat_v, rout_ready;
  erm_pkg::trig_t sx, cx, sy, cy, sz, cz;
  erm_pkg::mat3_t mat;

  assign en              = !mat_v || rout_ready;
  assign s_axis_tready_o = en;

  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .angle_i (s_axis_tdata_i[15:0]),
    .valid_o (vx),
    .sin_o   (sx),
    .cos_o   (cx)
  );

  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .angle_i (s_axis_tdata_i[31:16]),
    .valid_o (vy),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .angle_i (s_axis_tdata_i[47:32]),
    .valid_o (vz),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  erm_matrix #(.ELEM_FRAC_BITS(ELEM_FRAC_BITS)) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vx & vy & vz),
    .sx_i    (sx),
    .cx_i    (cx),
    .sy_i    (sy),
    .cy_i    (cy),
    .sz_i    (sz),
    .cz_i    (cz),
    .valid_o (mat_v),
    .mat_o   (mat)
  );

  erm_row_out #(.ELEM_FRAC_BITS(ELEM_FRAC_BITS)) u_row_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (mat_v),
    .mat_i           (mat),
    .ready_o         (rout_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: src/erm_sine_kernel.sv
// Pipelined sin(u*pi/2) kernel: Taylor series in Horner form, u in unsigned Q30.
module erm_sine_kernel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  erm_pkg::q30_t u_i,
  output logic          valid_o,
  output erm_pkg::q30_t sin_o
);

  localparam int NT = erm_pkg::HORNER_TERMS;

  logic [61:0] xp, x2p;
  logic [30:0] x_q, xk_q;
  logic [31:0] x2_q;
  logic        v0_q, v1_q;

  assign xp  = 62'(u_i) * 62'(erm_pkg::PI_2_Q30) + erm_pkg::Q30_HALF;
  assign x2p = 62'(x_q) * 62'(x_q) + erm_pkg::Q30_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= xp[60:30];
      x2_q <= x2p[61:30];
      xk_q <= x_q;
    end
  end

  // Horner chain, one group of three stages per term
  logic [30:0] s_c  [0:NT];
  logic [31:0] x2_c [0:NT];
  logic [30:0] x_c  [0:NT];
  logic        v_c  [0:NT];

  assign s_c[0]  = erm_pkg::Q30_ONE;
  assign x2_c[0] = x2_q;
  assign x_c[0]  = xk_q;
  assign v_c[0]  = v1_q;

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int          DIV = erm_pkg::horner_div(NT - j);
    localparam longint      MR  = ((64'sd1 <<< 41) + longint'(DIV) - 1) / longint'(DIV);
    localparam logic [15:0] ML  = 16'(MR);
    localparam logic [23:0] MH  = 24'(MR >>> 16);

    logic [62:0] tp;
    logic [71:0] qsum;
    logic [31:0] t_q;
    logic [47:0] plo_q;
    logic [55:0] phi_q;
    logic [31:0] x2a_q, x2b_q, x2c_q;
    logic [30:0] xa_q, xb_q, xc_q, s_q;
    logic [2:0]  v_q;

    assign tp   = 63'(x2_c[j]) * 63'(s_c[j]) + 63'(erm_pkg::Q30_HALF);
    assign qsum = 72'(plo_q) + (72'(phi_q) << 16);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= '0;
      end else if (en_i) begin
        v_q <= {v_q[1:0], v_c[j]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q   <= tp[61:30];
        x2a_q <= x2_c[j];
        xa_q  <= x_c[j];
        plo_q <= 48'(t_q) * 48'(ML);
        phi_q <= 56'(t_q) * 56'(MH);
        x2b_q <= x2a_q;
        xb_q  <= xa_q;
        // floor(t / DIV) by reciprocal, exact for 32-bit t
        s_q   <= erm_pkg::Q30_ONE - 31'(qsum >> 41);
        x2c_q <= x2b_q;
        xc_q  <= xb_q;
      end
    end

    assign s_c[j+1]  = s_q;
    assign x2_c[j+1] = x2c_q;
    assign x_c[j+1]  = xc_q;
    assign v_c[j+1]  = v_q[2];
  end

  logic [61:0] yp;
  logic [31:0] y;
  logic        vo_q;

  assign yp = 62'(x_c[NT]) * 62'(s_c[NT]) + erm_pkg::Q30_HALF;
  assign y  = yp[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_c[NT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= (y > 32'(erm_pkg::Q30_ONE)) ? erm_pkg::Q30_ONE : y[30:0];
    end
  end

  assign valid_o = vo_q;

endmodule

// File: src/erm_sincos.sv
// Angle reduction to quadrant and quarter-turn fraction, two sine kernels, sign fix-up.
module erm_sincos #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [15:0]   angle_i,
  output logic                 valid_o,
  output erm_pkg::trig_t       sin_o,
  output erm_pkg::trig_t       cos_o
);

  localparam int     F       = ANGLE_FRAC_BITS;
  localparam int     QUARTER = erm_pkg::DEG_QUARTER << F;
  localparam int     FULL    = 4 * QUARTER;
  localparam int     KWRAP   = (32768 + FULL - 1) / FULL;
  localparam int     OFFSET  = KWRAP * FULL;
  localparam int     AW      = $clog2(OFFSET + 32768);
  localparam int     QW      = $clog2(QUARTER);
  localparam int     S1      = AW + QW;
  localparam longint M1      = ((64'sd1 <<< S1) + longint'(QUARTER) - 1) / longint'(QUARTER);
  localparam int     M1W     = $clog2(M1 + 1);
  localparam int     S2      = QW + 7;
  localparam longint M2      = ((64'sd1 <<< S2) + longint'(erm_pkg::DEG_QUARTER) - 1)
                               / longint'(erm_pkg::DEG_QUARTER);
  localparam int     M2W     = $clog2(M2 + 1);
  localparam int     FW      = (F > 0) ? F : 1;
  localparam int     CS      = 22;
  localparam int     MC      = ((1 << CS) + erm_pkg::DEG_QUARTER - 1) / erm_pkg::DEG_QUARTER;
  localparam int     NCHUNK  = 4;
  localparam int     RED_LAT = 6 + NCHUNK;
  localparam int     QD      = RED_LAT - 3 + erm_pkg::KERNEL_LAT + 1;

  logic [RED_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RED_LAT-2:0], valid_i};
    end
  end

  // Stage 1: bias to a non-negative value that is a whole number of turns away
  // Stage 2: quotient by a quarter turn via reciprocal
  // Stage 3: remainder b and quadrant
  logic [AW-1:0]      a1_q, a2_q, qq_q;
  logic [AW+M1W-1:0]  p1;
  logic [QW-1:0]      b3_q, b4_q;
  logic [QW+M2W-1:0]  p2;
  logic [FW-1:0]      q04_q, q05_q;
  logic [6:0]         r5_q;

  assign p1 = (AW + M1W)'(a1_q) * (AW + M1W)'(M1);
  assign p2 = (QW + M2W)'(b3_q) * (QW + M2W)'(M2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= AW'(int'(angle_i) + OFFSET);
      qq_q  <= AW'(p1 >> S1);
      a2_q  <= a1_q;
      b3_q  <= QW'(a2_q - AW'(qq_q * AW'(QUARTER)));
      q04_q <= FW'(p2 >> S2);
      b4_q  <= b3_q;
      r5_q  <= 7'(b4_q - QW'(QW'(q04_q) * QW'(erm_pkg::DEG_QUARTER)));
      q05_q <= q04_q;
    end
  end

  // Long division of the remainder by 90, one byte per stage
  logic [6:0]    r_c  [0:NCHUNK];
  logic [31:0]   dg_c [0:NCHUNK];
  logic [FW-1:0] q0_c [0:NCHUNK];

  assign r_c[0]  = r5_q;
  assign dg_c[0] = '0;
  assign q0_c[0] = q05_q;

  for (genvar c = 0; c < NCHUNK; c++) begin : g_chunk
    logic [14:0]   v;
    logic [31:0]   pm;
    logic [7:0]    dq;
    logic [6:0]    r_q;
    logic [31:0]   dg_q;
    logic [FW-1:0] q0_q;

    assign v  = {r_c[c], 8'h00};
    assign pm = 32'(v) * 32'(MC);
    assign dq = 8'(pm >> CS);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q  <= 7'(v - 15'(15'(dq) * 15'(erm_pkg::DEG_QUARTER)));
        dg_q <= {dg_c[c][23:0], dq};
        q0_q <= q0_c[c];
      end
    end

    assign r_c[c+1]  = r_q;
    assign dg_c[c+1] = dg_q;
    assign q0_c[c+1] = q0_q;
  end

  // u = round(b * 2^30 / quarter), from floor(b * 2^(31-F) / 90)
  logic [FW+31:0] dfull;
  logic [31:0]    ud;
  logic [30:0]    ur;
  erm_pkg::q30_t  u_q, um_q;

  assign dfull = {q0_c[NCHUNK], dg_c[NCHUNK]};
  assign ud    = 32'(dfull >> (F + 1)) + 32'd1;
  assign ur    = (ud[31:1] > erm_pkg::Q30_ONE) ? erm_pkg::Q30_ONE : ud[31:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= ur;
      um_q <= erm_pkg::Q30_ONE - ur;
    end
  end

  logic          ka_v, kb_v;
  erm_pkg::q30_t sb, sc;

  erm_sine_kernel u_ker_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[RED_LAT-1]),
    .u_i     (u_q),
    .valid_o (ka_v),
    .sin_o   (sb)
  );

  erm_sine_kernel u_ker_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_q[RED_LAT-1]),
    .u_i     (um_q),
    .valid_o (kb_v),
    .sin_o   (sc)
  );

  // Quadrant rides alongside from stage 3 to the sign stage
  logic [1:0] quad_q [0:QD-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= qq_q[1:0];
      for (int i = 1; i < QD; i++) begin
        quad_q[i] <= quad_q[i-1];
      end
    end
  end

  erm_pkg::trig_t sbs, scs;
  logic           vo_q;

  assign sbs = 32'(sb);
  assign scs = 32'(sc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= ka_v & kb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[QD-1])
        2'd0: begin
          sin_o <= sbs;
          cos_o <= scs;
        end
        2'd1: begin
          sin_o <= scs;
          cos_o <= -sbs;
        end
        2'd2: begin
          sin_o <= -sbs;
          cos_o <= -scs;
        end
        default: begin
          sin_o <= -scs;
          cos_o <= sbs;
        end
      endcase
    end
  end

  assign valid_o = vo_q;

endmodule

// File: src/erm_matrix.sv
// Product and sum pipeline for Rz*Ry*Rx, rounded and saturated to 16-bit elements.
module erm_matrix #(
  parameter int ELEM_FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  erm_pkg::trig_t sx_i,
  input  erm_pkg::trig_t cx_i,
  input  erm_pkg::trig_t sy_i,
  input  erm_pkg::trig_t cy_i,
  input  erm_pkg::trig_t sz_i,
  input  erm_pkg::trig_t cz_i,
  output logic           valid_o,
  output erm_pkg::mat3_t mat_o
);

  localparam int SH = 60 - ELEM_FRAC_BITS;

  function automatic logic [15:0] emit(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + (66'sd1 <<< (SH - 1))) >>> SH;
    if (r > 66'sd32767) begin
      return 16'h7FFF;
    end else if (r < -66'sd32768) begin
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  logic [4:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stage 1: all two-factor products
  logic signed [63:0] pyx_q, pyc_q, czcy_q, szcx_q, szsx_q, szcy_q, czcx_q, czsx_q;
  logic signed [63:0] cysx_q, cycx_q;
  erm_pkg::trig_t     cz1_q, sz1_q, sy1_q;
  // Stage 2: inner products rounded to Q30
  erm_pkg::trig_t     syx_q, syc_q, cz2_q, sz2_q, sy2_q;
  logic signed [63:0] czcy2_q, szcx2_q, szsx2_q, szcy2_q, czcx2_q, czsx2_q;
  logic signed [63:0] cysx2_q, cycx2_q;
  // Stage 3: three-factor products
  logic signed [63:0] a3_q, b3_q, c3_q, d3_q;
  logic signed [63:0] czcy3_q, szcx3_q, szsx3_q, szcy3_q, czcx3_q, czsx3_q;
  logic signed [63:0] cysx3_q, cycx3_q;
  erm_pkg::trig_t     sy3_q;
  // Stage 4: exact Q60 sums
  logic signed [65:0] e_q [0:2][0:2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pyx_q  <= 64'(sy_i) * 64'(sx_i);
      pyc_q  <= 64'(sy_i) * 64'(cx_i);
      czcy_q <= 64'(cz_i) * 64'(cy_i);
      szcx_q <= 64'(sz_i) * 64'(cx_i);
      szsx_q <= 64'(sz_i) * 64'(sx_i);
      szcy_q <= 64'(sz_i) * 64'(cy_i);
      czcx_q <= 64'(cz_i) * 64'(cx_i);
      czsx_q <= 64'(cz_i) * 64'(sx_i);
      cysx_q <= 64'(cy_i) * 64'(sx_i);
      cycx_q <= 64'(cy_i) * 64'(cx_i);
      cz1_q  <= cz_i;
      sz1_q  <= sz_i;
      sy1_q  <= sy_i;

      syx_q   <= 32'((pyx_q + 64'sd536870912) >>> 30);
      syc_q   <= 32'((pyc_q + 64'sd536870912) >>> 30);
      cz2_q   <= cz1_q;
      sz2_q   <= sz1_q;
      sy2_q   <= sy1_q;
      czcy2_q <= czcy_q;
      szcx2_q <= szcx_q;
      szsx2_q <= szsx_q;
      szcy2_q <= szcy_q;
      czcx2_q <= czcx_q;
      czsx2_q <= czsx_q;
      cysx2_q <= cysx_q;
      cycx2_q <= cycx_q;

      a3_q    <= 64'(cz2_q) * 64'(syx_q);
      b3_q    <= 64'(cz2_q) * 64'(syc_q);
      c3_q    <= 64'(sz2_q) * 64'(syx_q);
      d3_q    <= 64'(sz2_q) * 64'(syc_q);
      czcy3_q <= czcy2_q;
      szcx3_q <= szcx2_q;
      szsx3_q <= szsx2_q;
      szcy3_q <= szcy2_q;
      czcx3_q <= czcx2_q;
      czsx3_q <= czsx2_q;
      cysx3_q <= cysx2_q;
      cycx3_q <= cycx2_q;
      sy3_q   <= sy2_q;

      e_q[0][0] <= 66'(czcy3_q);
      e_q[0][1] <= -66'(a3_q) - 66'(szcx3_q);
      e_q[0][2] <= -66'(b3_q) + 66'(szsx3_q);
      e_q[1][0] <= 66'(szcy3_q);
      e_q[1][1] <= -66'(c3_q) + 66'(czcx3_q);
      e_q[1][2] <= -66'(d3_q) - 66'(czsx3_q);
      e_q[2][0] <= 66'(sy3_q) <<< 30;
      e_q[2][1] <= 66'(cysx3_q);
      e_q[2][2] <= 66'(cycx3_q);

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat_o[r][c] <= emit(e_q[r][c]);
        end
      end
    end
  end

  assign valid_o = vld_q[4];

endmodule

// File: src/erm_row_out.sv
// Output stage: holds one matrix and sends it as four row words.
module erm_row_out #(
  parameter int ELEM_FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  erm_pkg::mat3_t mat_i,
  output logic           ready_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [71:0]    m_axis_tdata_o,
  output logic           m_axis_tlast_o
);

  localparam logic [15:0] ONE_ELEM = (ELEM_FRAC_BITS >= 15) ? 16'h7FFF
                                                            : 16'(1 << ELEM_FRAC_BITS);

  logic           busy_q;
  logic [1:0]     row_q;
  erm_pkg::mat3_t mat_q;
  logic           load;
  logic           is_last;
  logic [15:0]    c0, c1, c2, c3;

  assign is_last = (row_q == erm_pkg::LAST_ROW);
  assign ready_o = !busy_q || (is_last && m_axis_tready_i);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (busy_q && m_axis_tready_i) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= mat_i;
    end
  end

  always_comb begin
    if (is_last) begin
      c0 = '0;
      c1 = '0;
      c2 = '0;
      c3 = ONE_ELEM;
    end else begin
      c0 = mat_q[row_q][0];
      c1 = mat_q[row_q][1];
      c2 = mat_q[row_q][2];
      c3 = '0;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = is_last;
  assign m_axis_tdata_o  = {6'b0, c3, c2, c1, c0, row_q};

  // a non-final row is followed directly by the next row
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (busy_q && m_axis_tready_i && !is_last) |=> (busy_q && row_q == $past(row_q) + 2'd1))
    else $error("row sequence broken");

  // a new matrix always starts at row 0
  a_load_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load |=> (busy_q && row_q == 2'd0))
    else $error("matrix load did not restart at row 0");

  // a matrix is never replaced before its last row is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (load && busy_q) |-> (is_last && m_axis_tready_i))
    else $error("matrix overwritten mid-frame");

endmodule

// File: tb/tb_euler_rotation_matrix.sv
// Testbench for euler_rotation_matrix: random and directed angle triples, rows checked.
`timescale 1ns / 1ps

module tb_euler_rotation_matrix;

  localparam int AFB = 6;
  localparam int EFB = 14;
  localparam logic [63:0] PI2 = 64'd1686629713;
  localparam logic [63:0] ONE30 = 64'd1 << 30;

  typedef struct packed {
    logic [1:0]  row;
    logic [15:0] c0, c1, c2, c3;
    logic        last;
  } row_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  logic [47:0] pending_triples[$];
  row_word_t   expected_rows[$];
  int          n_errors = 0;
  int          n_triples = 0;
  int          n_rows = 0;
  bit          calm = 1'b0;
  bit          in_fire = 1'b0;

  euler_rotation_matrix dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Rounding right shift by sh bits with ties toward plus infinity, arithmetic shift floors
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] sine_q30(logic [63:0] u);
    logic [63:0] x, x2, s;
    x = qmul(u, PI2);
    x2 = qmul(x, x);
    s = ONE30;
    for (int k = 8; k >= 1; k--) s = ONE30 - qmul(x2, s) / ((2 * k) * (2 * k + 1));
    s = qmul(x, s);
    return (s > ONE30) ? ONE30 : s;
  endfunction

  task automatic trig_of(input logic [15:0] ang, output longint sn, output longint cs);
    longint full, quarter, r, q, b;
    logic [63:0] u, sb, sc;
    full = 360 << AFB;
    quarter = 90 << AFB;
    r = longint'($signed(ang)) % full;
    if (r < 0) r += full;
    q = r / quarter;
    b = r - q * quarter;
    u = ((64'(b) << 30) + 64'(quarter / 2)) / 64'(quarter);
    if (u > ONE30) u = ONE30;
    sb = sine_q30(u);
    sc = sine_q30(ONE30 - u);
    case (q & 3)
      0: begin sn = sb; cs = sc; end
      1: begin sn = sc; cs = -longint'(sb); end
      2: begin sn = -longint'(sb); cs = -longint'(sc); end
      default: begin sn = -longint'(sc); cs = sb; end
    endcase
  endtask

  function automatic logic [15:0] to_elem(longint v);
    longint r;
    r = rnd_shift(v, 60 - EFB);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_matrix(input logic [47:0] t);
    longint sx, cx, sy, cy, sz, cz, syx, syc, one;
    logic [15:0] m[4][4];
    row_word_t w;
    trig_of(t[15:0], sx, cx);
    trig_of(t[31:16], sy, cy);
    trig_of(t[47:32], sz, cz);
    one = ONE30;
    syx = rnd_shift(sy * sx, 30);
    syc = rnd_shift(sy * cx, 30);
    m[0][0] = to_elem(cz * cy);
    m[0][1] = to_elem(-(cz * syx) - sz * cx);
    m[0][2] = to_elem(-(cz * syc) + sz * sx);
    m[1][0] = to_elem(sz * cy);
    m[1][1] = to_elem(-(sz * syx) + cz * cx);
    m[1][2] = to_elem(-(sz * syc) - cz * sx);
    m[2][0] = to_elem(sy * one);
    m[2][1] = to_elem(cy * sx);
    m[2][2] = to_elem(cy * cx);
    for (int i = 0; i < 3; i++) begin
      m[i][3] = '0;
      m[3][i] = '0;
    end
    m[3][3] = ((1 << EFB) > 32767) ? 16'd32767 : 16'(1 << EFB);
    for (int i = 0; i < 4; i++) begin
      w.row = 2'(i);
      w.c0 = m[i][0];
      w.c1 = m[i][1];
      w.c2 = m[i][2];
      w.c3 = m[i][3];
      w.last = (i == 3);
      expected_rows.push_back(w);
    end
  endtask

  // driver: valid held until the word is taken at a rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) void'(pending_triples.pop_front());
      if (!s_axis_tvalid_i || in_fire) begin
        if (pending_triples.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= pending_triples[0];
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_fire) begin
      predict_matrix(s_axis_tdata_i);
      n_triples++;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    row_word_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_rows++;
      if (expected_rows.size() == 0) begin
        $error("unexpected row word %h", m_axis_tdata_o);
        n_errors++;
      end else begin
        e = expected_rows.pop_front();
        if (m_axis_tdata_o[1:0] !== e.row) begin
          $error("row_index exp %0d got %0d", e.row, m_axis_tdata_o[1:0]); n_errors++;
        end
        if (m_axis_tdata_o[17:2] !== e.c0) begin
          $error("elem_col0 exp %h got %h", e.c0, m_axis_tdata_o[17:2]); n_errors++;
        end
        if (m_axis_tdata_o[33:18] !== e.c1) begin
          $error("elem_col1 exp %h got %h", e.c1, m_axis_tdata_o[33:18]); n_errors++;
        end
        if (m_axis_tdata_o[49:34] !== e.c2) begin
          $error("elem_col2 exp %h got %h", e.c2, m_axis_tdata_o[49:34]); n_errors++;
        end
        if (m_axis_tdata_o[65:50] !== e.c3) begin
          $error("elem_col3 exp %h got %h", e.c3, m_axis_tdata_o[65:50]); n_errors++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_row exp %0b got %0b", e.last, m_axis_tlast_o); n_errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom_range(360) << AFB);       // whole degrees
      1: return 16'(($urandom_range(8) * 45) << AFB);  // octant points
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges[10];
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'd5760, 16'd11520,
              16'd17280, 16'd23040, -16'sd5760, 16'h0001};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // directed: axis extremes and quadrant boundaries on x, a subset of them on y and on z
    for (int i = 0; i < 10; i++) begin
      pending_triples.push_back({16'h0, 16'h0, edges[i]});
      if (i % 3 == 0) pending_triples.push_back({16'h0, edges[i], 16'h0});
      if (i % 3 != 0) pending_triples.push_back({edges[i], 16'h0, edges[9 - i]});
    end
    pending_triples.push_back({16'hffff, 16'hffff, 16'hffff});
    pending_triples.push_back({16'h8000, 16'h8000, 16'h8000});
    for (int i = 0; i < 230; i++) begin
      if (i == 100) begin
        wait (pending_triples.size() == 0);
        calm = 1'b1;
      end
      if (i == 160) begin
        wait (pending_triples.size() == 0);
        calm = 1'b0;
      end
      pending_triples.push_back({rand_angle(), rand_angle(), rand_angle()});
    end
    wait (pending_triples.size() == 0 && !s_axis_tvalid_i);
    wait (expected_rows.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d angle triples, %0d matrix rows checked.", n_triples, n_rows);
    if (n_errors == 0 && expected_rows.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
